@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/bms_pkg.sv @@
// Package with types, constants and the note table of the melody sequencer.
`timescale 1ns / 1ps
`default_nettype none
package bms_pkg;

   localparam int SONG_DEPTH_DEF     = 64;
   localparam int TIMER_CLOCK_HZ_DEF = 1000000;
   localparam int DIVISOR_W          = 13;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 7;
   localparam int RELOAD_MAX         = 65535;
   localparam logic [5:0] END_NOTE   = 6'd61;
   localparam logic [6:0] LOUD_SPAN  = 7'd100;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_LOUDNESS = 2'd1,
      CSR_SPARE2   = 2'd2,
      CSR_SPARE3   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  entry_index;
      logic [5:0]  entry_note;
      logic [15:0] entry_delay;
   } req_word_type;

   typedef struct packed {
      logic [15:0] reload_value;
      logic [15:0] duty_value;
      logic        tone_on;
      logic        note_changed;
      logic        playing;
   } rsp_word_type;

   typedef struct packed {
      logic                 start;
      logic [DIVISOR_W-1:0] divisor;
   } div_ctl_type;

   function automatic logic [DIVISOR_W-1:0] note_hz(input logic [5:0] note);
      logic [DIVISOR_W-1:0] hz;
      case (note)
         6'd1:  hz = 13'd262;   6'd2:  hz = 13'd277;   6'd3:  hz = 13'd294;
         6'd4:  hz = 13'd311;   6'd5:  hz = 13'd330;   6'd6:  hz = 13'd349;
         6'd7:  hz = 13'd370;   6'd8:  hz = 13'd392;   6'd9:  hz = 13'd415;
         6'd10: hz = 13'd440;   6'd11: hz = 13'd466;   6'd12: hz = 13'd494;
         6'd13: hz = 13'd523;   6'd14: hz = 13'd554;   6'd15: hz = 13'd587;
         6'd16: hz = 13'd622;   6'd17: hz = 13'd659;   6'd18: hz = 13'd698;
         6'd19: hz = 13'd740;   6'd20: hz = 13'd784;   6'd21: hz = 13'd830;
         6'd22: hz = 13'd880;   6'd23: hz = 13'd932;   6'd24: hz = 13'd988;
         6'd25: hz = 13'd1047;  6'd26: hz = 13'd1109;  6'd27: hz = 13'd1175;
         6'd28: hz = 13'd1245;  6'd29: hz = 13'd1319;  6'd30: hz = 13'd1397;
         6'd31: hz = 13'd1480;  6'd32: hz = 13'd1568;  6'd33: hz = 13'd1661;
         6'd34: hz = 13'd1760;  6'd35: hz = 13'd1865;  6'd36: hz = 13'd1976;
         6'd37: hz = 13'd2093;  6'd38: hz = 13'd2218;  6'd39: hz = 13'd2349;
         6'd40: hz = 13'd2489;  6'd41: hz = 13'd2637;  6'd42: hz = 13'd2794;
         6'd43: hz = 13'd2960;  6'd44: hz = 13'd3136;  6'd45: hz = 13'd3322;
         6'd46: hz = 13'd3520;  6'd47: hz = 13'd3729;  6'd48: hz = 13'd3951;
         6'd49: hz = 13'd4186;  6'd50: hz = 13'd4435;  6'd51: hz = 13'd4699;
         6'd52: hz = 13'd4978;  6'd53: hz = 13'd5274;  6'd54: hz = 13'd5588;
         6'd55: hz = 13'd5920;  6'd56: hz = 13'd6272;  6'd57: hz = 13'd6645;
         6'd58: hz = 13'd7040;  6'd59: hz = 13'd7459;  6'd60: hz = 13'd7902;
         default: hz = '0;
      endcase
      return hz;
   endfunction

endpackage
`default_nettype wire

@@ rtl/bms_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bms_div
   import bms_pkg::*;
#(
   parameter int DIVIDEND_W = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_ctl_type           ctl,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic                       done
);

   localparam int CW = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = ctl.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

@@ rtl/buzzer_melody_sequencer.sv @@
// Top level of the buzzer melody sequencer: song memory, sequencer and output register.
// Write, no-op and plain tick words pass from idle to the output state; start scans
// the song entry by entry to the end note or last entry. A note-loading tick reads it;
// a rest goes to output, else both divisions use one serial divider, one bit per cycle.
// One word is in work at a time; req_stall is high until its result is registered.
// Reset is synchronous; control registers clear, scan, response and memories do not.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module buzzer_melody_sequencer
   import bms_pkg::*;
#(
   parameter int SONG_DEPTH     = SONG_DEPTH_DEF,
   parameter int TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_word_type           req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_word_type                rsp_word,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW     = $clog2(SONG_DEPTH);
   localparam int HZ_W   = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int DIV_W  = (HZ_W > 16) ? HZ_W : 16;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SCAN_RD   = 8'b0000_0010,
      S_SCAN_CHK  = 8'b0000_0100,
      S_LOAD_RD   = 8'b0000_1000,
      S_LOAD_NOTE = 8'b0001_0000,
      S_DIV1      = 8'b0010_0000,
      S_DIV2      = 8'b0100_0000,
      S_OUT       = 8'b1000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [5:0]     notes_mem [SONG_DEPTH];
   logic [15:0]    delays_mem [SONG_DEPTH];
   logic [5:0]     note_rd_ff;
   logic [15:0]    delay_rd_ff;
   logic [AW-1:0]  rd_addr;

   logic [AW-1:0]  len_ff, len_in;
   logic [AW:0]    pos_ff, pos_in;
   logic [AW-1:0]  scan_ff, scan_in;
   logic [15:0]    counter_ff, counter_in;
   logic           active_ff, active_in;
   logic           buzzer_ff, buzzer_in;
   logic           changed_ff, changed_in;
   logic [15:0]    period_ff, period_in;
   logic [15:0]    compare_ff, compare_in;
   logic           enable_ff;
   logic [6:0]     loudness_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff;
   logic           rsp_load;

   logic           req_accept;
   logic           wr_en;
   div_ctl_type    div_ctl;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_quo;
   logic           div_done;
   logic [DIVISOR_W-1:0] hz;
   logic [6:0]     duty_div;
   logic [15:0]    period_sat;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign hz         = note_hz(note_rd_ff);
   assign duty_div   = (loudness_ff < LOUD_SPAN) ? (LOUD_SPAN - loudness_ff) : 7'd1;
   assign period_sat = (div_quo > DIV_W'(RELOAD_MAX)) ? 16'hFFFF : div_quo[15:0];

   assign wr_en   = req_accept && (op_type'(req_word.opcode) == OP_WRITE)
                    && (int'(req_word.entry_index) < SONG_DEPTH);
   assign rd_addr = (state_ff == S_LOAD_RD) ? pos_ff[AW-1:0] : scan_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         notes_mem[AW'(req_word.entry_index)]  <= req_word.entry_note;
         delays_mem[AW'(req_word.entry_index)] <= req_word.entry_delay;
      end
      note_rd_ff  <= notes_mem[rd_addr];
      delay_rd_ff <= delays_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         loudness_ff <= 7'd20;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:   enable_ff   <= csr_data[0];
            CSR_LOUDNESS: loudness_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      counter_in   = counter_ff;
      active_in    = active_ff;
      buzzer_in    = buzzer_ff;
      changed_in   = changed_ff;
      period_in    = period_ff;
      compare_in   = compare_ff;
      rsp_load     = 1'b0;
      div_ctl      = '0;
      div_dividend = DIV_W'(TIMER_CLOCK_HZ);
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               changed_in = 1'b0;
               state_in   = S_OUT;
               case (op_type'(req_word.opcode))
                  OP_TICK: begin
                     if (active_ff && enable_ff && (pos_ff <= {1'b0, len_ff})) begin
                        counter_in = counter_ff - 16'd1;
                        if (counter_ff == 16'd0) begin
                           state_in = S_LOAD_RD;
                        end
                     end else begin
                        buzzer_in = 1'b0;
                        active_in = 1'b0;
                     end
                  end
                  OP_START: begin
                     scan_in  = '0;
                     state_in = S_SCAN_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if ((note_rd_ff == END_NOTE) || (scan_ff == AW'(SONG_DEPTH - 1))) begin
               len_in     = scan_ff;
               buzzer_in  = 1'b0;
               pos_in     = '0;
               counter_in = '0;
               active_in  = 1'b1;
               state_in   = S_OUT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_LOAD_RD: begin
            state_in = S_LOAD_NOTE;
         end
         S_LOAD_NOTE: begin
            counter_in = delay_rd_ff;
            pos_in     = pos_ff + 1'b1;
            buzzer_in  = 1'b1;
            changed_in = 1'b1;
            if (hz == '0) begin
               period_in  = '0;
               compare_in = '0;
               state_in   = S_OUT;
            end else begin
               div_ctl.start   = 1'b1;
               div_ctl.divisor = hz;
               state_in        = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               period_in       = period_sat;
               div_ctl.start   = 1'b1;
               div_ctl.divisor = DIVISOR_W'(duty_div);
               div_dividend    = DIV_W'(period_sat);
               state_in        = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               compare_in = div_quo[15:0];
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pos_ff       <= '0;
         counter_ff   <= '0;
         active_ff    <= 1'b0;
         buzzer_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         period_ff    <= '0;
         compare_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         counter_ff   <= counter_in;
         active_ff    <= active_in;
         buzzer_ff    <= buzzer_in;
         changed_ff   <= changed_in;
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff <= scan_in;
      if (rsp_load) begin
         rsp_word_ff.reload_value <= period_ff;
         rsp_word_ff.duty_value   <= compare_ff;
         rsp_word_ff.tone_on      <= buzzer_ff;
         rsp_word_ff.note_changed <= changed_ff;
         rsp_word_ff.playing      <= active_ff;
      end
   end

   bms_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_ALWAYS(a_pos_bound, pos_ff <= ((AW+1)'(len_ff) + 1'b1), "play position past song end")
   `ASSERT_IMPLY(a_div_owner, div_done, (state_ff == S_DIV1) || (state_ff == S_DIV2), "stray divider result")
   `ASSERT_IMPLY(a_change_sounds, rsp_valid && rsp_word.note_changed, rsp_word.tone_on && rsp_word.playing, "note load without tone")

endmodule
`default_nettype wire
